// ===== rtl/core/ubp_pkg.sv =====
// ============================================================================
// ubp_pkg
// Shared types, constants and the exponential table builder for the
// underwater backscatter pixel pipeline.
// ============================================================================
package ubp_pkg;

  localparam int LANE_W         = 16;
  localparam int DEPTH_W        = 16;
  localparam int T_W            = 32;
  localparam int EXP_W          = 17;
  localparam int EXP_FRAC_SHIFT = 26;
  localparam int PROD_W         = LANE_W + EXP_W;
  localparam int ACC_W          = PROD_W + 1;
  localparam int OUT_SHIFT      = 18;

  localparam logic [EXP_W-1:0] EXP_ONE    = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_BIAS = 34'h20000;
  localparam logic [63:0]      EXP_M1_Q32 = 64'd1580030169;

  typedef logic [LANE_W-1:0] ubp_lane_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } ubp_stage_en_t;

  function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
    logic [63:0] q;
    case (k)
      1:  q = v / 64'd1;
      2:  q = v / 64'd2;
      3:  q = v / 64'd3;
      4:  q = v / 64'd4;
      5:  q = v / 64'd5;
      6:  q = v / 64'd6;
      7:  q = v / 64'd7;
      8:  q = v / 64'd8;
      9:  q = v / 64'd9;
      10: q = v / 64'd10;
      11: q = v / 64'd11;
      12: q = v / 64'd12;
      13: q = v / 64'd13;
      14: q = v / 64'd14;
      15: q = v / 64'd15;
      16: q = v / 64'd16;
      17: q = v / 64'd17;
      18: q = v / 64'd18;
      19: q = v / 64'd19;
      20: q = v / 64'd20;
      21: q = v / 64'd21;
      22: q = v / 64'd22;
      23: q = v / 64'd23;
      24: q = v / 64'd24;
      default: q = v;
    endcase
    return q;
  endfunction

  // Table entry for exp(-x / 2^32) in Q1.16: a series for the fraction,
  // then one multiply by exp(-1) per whole unit.
  function automatic logic [EXP_W-1:0] exp_rom_entry(input logic [63:0] x);
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] frac;
    logic [63:0] whole;
    frac  = {32'b0, x[31:0]};
    whole = {32'b0, x[63:32]};
    s     = 64'h1_0000_0000;
    term  = 64'h1_0000_0000;
    for (int k = 1; k <= 24; k++) begin
      term = div_small((term * frac) >> 32, k);
      if (k[0]) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    for (int j = 0; j < 64; j++) begin
      if (64'(j) < whole) begin
        s = (s * EXP_M1_Q32) >> 32;
      end
    end
    return EXP_W'((s + 64'd32768) >> 16);
  endfunction

endpackage

// ===== rtl/core/ubp_exp_unit.sv =====
// ============================================================================
// ubp_exp_unit
// Three-stage exp(-t) lookup: table index, table read, linear interpolation.
// ============================================================================
module ubp_exp_unit #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  ubp_pkg::ubp_stage_en_t              stg_en,
  input  logic [ubp_pkg::T_W-1:0]             t_in,
  output logic [ubp_pkg::EXP_W-1:0]           e_out
);
  import ubp_pkg::*;

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int P_W   = T_W + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int HI_W  = P_W - EXP_FRAC_SHIFT;
  localparam int MUL_W = EXP_W + EXP_FRAC_SHIFT;

  logic [EXP_W-1:0] rom_e   [EXP_TABLE_DEPTH];
  logic [EXP_W-1:0] rom_dlt [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] X0 = (64'(gi) << 36) / EXP_TABLE_DEPTH;
    localparam logic [63:0] X1 = (64'(gi + 1) << 36) / EXP_TABLE_DEPTH;
    localparam logic [EXP_W-1:0] E0 = exp_rom_entry(X0);
    localparam logic [EXP_W-1:0] E1 = exp_rom_entry(X1);
    assign rom_e[gi]   = E0;
    assign rom_dlt[gi] = (E1 > E0) ? '0 : (E0 - E1);
  end

  logic [P_W-1:0]            p;
  logic [HI_W-1:0]           p_hi;
  logic [IDX_W-1:0]          idx_r;
  logic [EXP_FRAC_SHIFT-1:0] frac_r;
  logic [EXP_FRAC_SHIFT-1:0] frac3_r;
  logic                      zero2_r;
  logic                      zero3_r;
  logic [EXP_W-1:0]          e0_r;
  logic [EXP_W-1:0]          dlt_r;
  logic [MUL_W-1:0]          step_prod;
  logic [EXP_W-1:0]          e_r;

  assign p         = P_W'(t_in) * P_W'(EXP_TABLE_DEPTH);
  assign p_hi      = p[P_W-1:EXP_FRAC_SHIFT];
  assign step_prod = MUL_W'(dlt_r) * MUL_W'(frac3_r);

  always_ff @(posedge clk) begin
    if (stg_en.s2) begin
      idx_r   <= p_hi[IDX_W-1:0];
      frac_r  <= p[EXP_FRAC_SHIFT-1:0];
      zero2_r <= (p_hi >= HI_W'(EXP_TABLE_DEPTH));
    end
    if (stg_en.s3) begin
      e0_r    <= rom_e[idx_r];
      dlt_r   <= rom_dlt[idx_r];
      frac3_r <= frac_r;
      zero3_r <= zero2_r;
    end
    if (stg_en.s4) begin
      e_r <= zero3_r ? '0 : (e0_r - step_prod[MUL_W-1:EXP_FRAC_SHIFT]);
    end
  end

  assign e_out = e_r;

endmodule

// ===== rtl/core/ubp_channel.sv =====
// ============================================================================
// ubp_channel
// One color channel: depth products, two exponentials, gain products and
// the rounded, saturated sum.
// ============================================================================
module ubp_channel #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  ubp_pkg::ubp_stage_en_t       stg_en,
  input  logic [ubp_pkg::DEPTH_W-1:0]  depth,
  input  ubp_pkg::ubp_lane_t           kb,
  input  ubp_pkg::ubp_lane_t           kr,
  input  ubp_pkg::ubp_lane_t           gb,
  input  ubp_pkg::ubp_lane_t           gr,
  input  logic                         res_en,
  output ubp_pkg::ubp_lane_t           value
);
  import ubp_pkg::*;

  localparam int V_W = ACC_W - OUT_SHIFT;

  logic [T_W-1:0]    tb_r;
  logic [T_W-1:0]    tr_r;
  logic [EXP_W-1:0]  eb;
  logic [EXP_W-1:0]  er;
  logic [PROD_W-1:0] pb_r;
  logic [PROD_W-1:0] pr_r;
  logic [ACC_W-1:0]  acc;
  logic [V_W-1:0]    v;
  ubp_lane_t         value_r;

  ubp_exp_unit #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_back (
    .clk    (clk),
    .stg_en (stg_en),
    .t_in   (tb_r),
    .e_out  (eb)
  );

  ubp_exp_unit #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_resid (
    .clk    (clk),
    .stg_en (stg_en),
    .t_in   (tr_r),
    .e_out  (er)
  );

  assign acc = ACC_W'(pb_r) + ACC_W'(pr_r) + ROUND_BIAS;
  assign v   = acc[ACC_W-1:OUT_SHIFT];

  always_ff @(posedge clk) begin
    if (stg_en.s1) begin
      tb_r <= T_W'(kb) * T_W'(depth);
      tr_r <= T_W'(kr) * T_W'(depth);
    end
    if (stg_en.s5) begin
      pb_r <= PROD_W'(gb) * PROD_W'(EXP_ONE - eb);
      pr_r <= res_en ? (PROD_W'(gr) * PROD_W'(er)) : '0;
    end
    if (stg_en.s6) begin
      value_r <= (v > V_W'(16'hFFFF)) ? 16'hFFFF : LANE_W'(v);
    end
  end

  assign value = value_r;

endmodule

// ===== rtl/core/underwater_backscatter_pixel.sv =====
// ============================================================================
// underwater_backscatter_pixel
// Per-pixel three-channel backscatter from one depth sample.
//
//   Channel | Ports         | Beat contents
//   --------+---------------+--------------------------------------------
//   input   | in_t*         | tdata[15:0] depth_sample
//   output  | out_t*        | tdata[15:0] chan0, [31:16] chan1, [47:32] chan2
//   config  | cfg_p*        | 64-bit registers at byte address 8*index
//
// Six register stages: depth product, table index, table read,
// interpolation, gain products, sum and saturation. One beat per cycle
// is sustained while out_tready stays high.
// Reset clears the stage valid bits and the configuration registers.
// A stalled output holds its beat; earlier stages keep filling bubbles.
// ============================================================================
module underwater_backscatter_pixel #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] depth_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] chan0_value, [31:16] chan1_value, [47:32] chan2_value
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ubp_pkg::*;

  localparam logic [2:0] REG_BETA_BACK  = 3'd0;
  localparam logic [2:0] REG_BETA_RESID = 3'd1;
  localparam logic [2:0] REG_VEIL_GAIN  = 3'd2;
  localparam logic [2:0] REG_RESID_GAIN = 3'd3;
  localparam logic [2:0] REG_RESID_EN   = 3'd4;

  logic [47:0]   beta_back_r;
  logic [47:0]   beta_resid_r;
  logic [47:0]   veil_gain_r;
  logic [47:0]   resid_gain_r;
  logic          resid_en_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  logic [5:0]    vld_r;
  ubp_stage_en_t stg_en;
  ubp_lane_t     chan_val [3];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_back_r  <= '0;
      beta_resid_r <= '0;
      veil_gain_r  <= '0;
      resid_gain_r <= '0;
      resid_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BETA_BACK:  beta_back_r  <= cfg_pwdata[47:0];
        REG_BETA_RESID: beta_resid_r <= cfg_pwdata[47:0];
        REG_VEIL_GAIN:  veil_gain_r  <= cfg_pwdata[47:0];
        REG_RESID_GAIN: resid_gain_r <= cfg_pwdata[47:0];
        REG_RESID_EN:   resid_en_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BETA_BACK:  cfg_prdata = {16'b0, beta_back_r};
      REG_BETA_RESID: cfg_prdata = {16'b0, beta_resid_r};
      REG_VEIL_GAIN:  cfg_prdata = {16'b0, veil_gain_r};
      REG_RESID_GAIN: cfg_prdata = {16'b0, resid_gain_r};
      REG_RESID_EN:   cfg_prdata = {63'b0, resid_en_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_comb begin
    stg_en.s6 = !vld_r[5] || out_tready;
    stg_en.s5 = !vld_r[4] || stg_en.s6;
    stg_en.s4 = !vld_r[3] || stg_en.s5;
    stg_en.s3 = !vld_r[2] || stg_en.s4;
    stg_en.s2 = !vld_r[1] || stg_en.s3;
    stg_en.s1 = !vld_r[0] || stg_en.s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en.s1) begin
        vld_r[0] <= in_tvalid;
      end
      if (stg_en.s2) begin
        vld_r[1] <= vld_r[0];
      end
      if (stg_en.s3) begin
        vld_r[2] <= vld_r[1];
      end
      if (stg_en.s4) begin
        vld_r[3] <= vld_r[2];
      end
      if (stg_en.s5) begin
        vld_r[4] <= vld_r[3];
      end
      if (stg_en.s6) begin
        vld_r[5] <= vld_r[4];
      end
    end
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_chan
    ubp_channel #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_chan (
      .clk    (clk),
      .stg_en (stg_en),
      .depth  (in_tdata),
      .kb     (beta_back_r[16*gc +: 16]),
      .kr     (beta_resid_r[16*gc +: 16]),
      .gb     (veil_gain_r[16*gc +: 16]),
      .gr     (resid_gain_r[16*gc +: 16]),
      .res_en (resid_en_r),
      .value  (chan_val[gc])
    );
  end

  assign in_tready  = stg_en.s1;
  assign out_tvalid = vld_r[5];
  assign out_tdata  = {chan_val[2], chan_val[1], chan_val[0]};

endmodule
